### src/depth_projective_warp_grid_core_macros.svh
// Assertion macros for the depth projective warp grid core.
// Used by depth_projective_warp_grid_core; expects clock and reset in scope.
`ifndef DEPTH_PROJECTIVE_WARP_GRID_CORE_MACROS_SVH
`define DEPTH_PROJECTIVE_WARP_GRID_CORE_MACROS_SVH

// Check that holds outside of reset.
`define DPWG_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dpwg assertion failed");

// Check that also covers the reset cycles.
`define DPWG_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("dpwg reset assertion failed");

`endif

### src/dpwg_pkg.sv
// Package for the depth projective warp grid core: widths, constants, types.
// No dependencies.
package dpwg_pkg;

   localparam int COL_W    = 12;
   localparam int ROW_W    = 12;
   localparam int DEPTH_W  = 24;
   localparam int COORD_W  = 32;
   localparam int MAX_COLS = 4096;
   localparam int MAX_ROWS = 4096;

   localparam int NUM_REGS  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;
   localparam int COEF_W    = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_A = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_B = 3'd5;

   localparam logic [CSR_W-1:0] COEF_RESET [NUM_REGS] = '{
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000,
      64'h0, 64'h0, 64'h0001_0000_0000_0000};

   // Product and sum widths
   localparam int PROD_UV_W = COEF_W + COL_W + 1;   // signed coef x unsigned coord
   localparam int PROD_Z_W  = COEF_W + DEPTH_W;
   localparam int SUM_W     = 64;

   // Divider widths
   localparam int DEN_W = 61;                       // |row sum| < 2^61
   localparam int QUO_W = 32;                       // 15 integer + 17 fraction bits
   localparam int FRAC_EXTRA = 17;
   localparam int REM_W = DEN_W + FRAC_EXTRA;
   localparam int CMP_W = DEN_W + QUO_W;

   localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic             ok;
      logic             neg_u;
      logic             neg_v;
      logic             sat_u;
      logic             sat_v;
      logic [REM_W-1:0] rem_u;
      logic [REM_W-1:0] rem_v;
      logic [QUO_W-1:0] q_u;
      logic [QUO_W-1:0] q_v;
      logic [DEN_W-1:0] den;
   } div_stage_type;

   // Round the 17-fraction-bit quotient to Q16.16, apply sign and saturation.
   function automatic logic [COORD_W-1:0] round_q16(input logic [QUO_W-1:0] q,
                                                   input logic neg, input logic sat);
      logic [QUO_W:0]     sum;
      logic [COORD_W-1:0] mag;
      logic [COORD_W-1:0] res;
      sum = {1'b0, q} + {{QUO_W{1'b0}}, 1'b1};
      mag = sum[QUO_W:1];
      if (sat) begin
         res = neg ? SAT_NEG : SAT_POS;
      end else if (neg) begin
         res = COORD_W'(0) - mag;
      end else if (mag > SAT_POS) begin
         res = SAT_POS;
      end else begin
         res = mag;
      end
      return res;
   endfunction

endpackage

### src/dpwg_if.sv
// Channel interfaces of the depth projective warp grid core.
// Depends on dpwg_pkg.
interface dpwg_req_if;
   logic                          valid;
   logic                          ready;
   logic [dpwg_pkg::COL_W-1:0]    pixel_column;
   logic [dpwg_pkg::ROW_W-1:0]    pixel_row;
   logic signed [dpwg_pkg::DEPTH_W-1:0] inverse_depth;
   logic                          frame_last;
   modport source (output valid, pixel_column, pixel_row, inverse_depth, frame_last,
                   input ready);
   modport sink (input valid, pixel_column, pixel_row, inverse_depth, frame_last,
                 output ready);
endinterface

interface dpwg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dpwg_pkg::COORD_W-1:0] warped_u;
   logic signed [dpwg_pkg::COORD_W-1:0] warped_v;
   logic                                valid_res;
   logic                                frame_last_out;
   modport source (output valid, warped_u, warped_v, valid_res, frame_last_out,
                   input ready);
   modport sink (input valid, warped_u, warped_v, valid_res, frame_last_out,
                 output ready);
endinterface

### src/dpwg_div.sv
// Pipelined restoring divider, two numerators over one shared denominator.
// Depends on dpwg_pkg. One quotient bit per stage, plus a saturation stage.
module dpwg_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  dpwg_pkg::div_stage_type div_in,
   output dpwg_pkg::div_stage_type div_out
);

   dpwg_pkg::div_stage_type stage_in [dpwg_pkg::QUO_W+1];
   dpwg_pkg::div_stage_type stage_ff [dpwg_pkg::QUO_W+1];

   // Saturation stage: integer part reaches 2^15 when mag >= den << 15
   always_comb begin
      stage_in[0] = div_in;
      stage_in[0].sat_u = dpwg_pkg::CMP_W'(div_in.rem_u)
                          >= (dpwg_pkg::CMP_W'(div_in.den) << dpwg_pkg::QUO_W);
      stage_in[0].sat_v = dpwg_pkg::CMP_W'(div_in.rem_v)
                          >= (dpwg_pkg::CMP_W'(div_in.den) << dpwg_pkg::QUO_W);
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 1; k <= dpwg_pkg::QUO_W; k++) begin : g_bit
      localparam int BIT = dpwg_pkg::QUO_W - k;
      logic [dpwg_pkg::CMP_W-1:0] dsh;
      logic [dpwg_pkg::CMP_W-1:0] diff_u;
      logic [dpwg_pkg::CMP_W-1:0] diff_v;
      logic                       ge_u;
      logic                       ge_v;
      always_comb begin
         dsh    = dpwg_pkg::CMP_W'(stage_ff[k-1].den) << BIT;
         ge_u   = dpwg_pkg::CMP_W'(stage_ff[k-1].rem_u) >= dsh;
         ge_v   = dpwg_pkg::CMP_W'(stage_ff[k-1].rem_v) >= dsh;
         diff_u = dpwg_pkg::CMP_W'(stage_ff[k-1].rem_u) - dsh;
         diff_v = dpwg_pkg::CMP_W'(stage_ff[k-1].rem_v) - dsh;
         stage_in[k] = stage_ff[k-1];
         if (ge_u) begin
            stage_in[k].rem_u    = diff_u[dpwg_pkg::REM_W-1:0];
            stage_in[k].q_u[BIT] = 1'b1;
         end
         if (ge_v) begin
            stage_in[k].rem_v    = diff_v[dpwg_pkg::REM_W-1:0];
            stage_in[k].q_v[BIT] = 1'b1;
         end
      end
   end

   // Stage registers; only the valid bits are reset
   for (genvar s = 0; s <= dpwg_pkg::QUO_W; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (en) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign div_out = stage_ff[dpwg_pkg::QUO_W];

endmodule

### src/depth_projective_warp_grid_core.sv
// Top level of the depth projective warp grid core: pixel reprojection pipeline.
// Depends on dpwg_pkg, dpwg_if, dpwg_div and the assertion macro header.
//
//  channel  | direction | payload
//  req_chan | in        | pixel_column, pixel_row, inverse_depth, frame_last
//  rsp_chan | out       | warped_u, warped_v, valid_res, frame_last_out
//  csr_*    | in        | csr_we, csr_index, csr_wdata (write only)
//
// One pixel per cycle sustained while results are taken.
// Two product/sum stages, 33 divider stages (saturation + one per quotient bit),
// then the output register.
// Synchronous active-high reset clears valid bits and loads coefficient defaults.
// A result not taken stalls the whole pipeline; nothing is lost or repeated.
`include "depth_projective_warp_grid_core_macros.svh"

module depth_projective_warp_grid_core (
   input  logic                            clock,
   input  logic                            reset,
   dpwg_req_if.sink                        req_chan,
   dpwg_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [dpwg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpwg_pkg::CSR_W-1:0]      csr_wdata
);

   logic [dpwg_pkg::CSR_W-1:0] coef_ff [dpwg_pkg::NUM_REGS];
   logic en;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dpwg_pkg::NUM_REGS; i++) coef_ff[i] <= dpwg_pkg::COEF_RESET[i];
      end else if (csr_we) begin
         case (csr_index)
            dpwg_pkg::REG_ROW0_A: coef_ff[0] <= csr_wdata;
            dpwg_pkg::REG_ROW0_B: coef_ff[1] <= csr_wdata;
            dpwg_pkg::REG_ROW1_A: coef_ff[2] <= csr_wdata;
            dpwg_pkg::REG_ROW1_B: coef_ff[3] <= csr_wdata;
            dpwg_pkg::REG_ROW2_A: coef_ff[4] <= csr_wdata;
            dpwg_pkg::REG_ROW2_B: coef_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Global advance: output register empty or being drained
   assign en = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: products per matrix row
   logic signed [dpwg_pkg::PROD_UV_W-1:0] au_ff [3];
   logic signed [dpwg_pkg::PROD_UV_W-1:0] bv_ff [3];
   logic signed [dpwg_pkg::COEF_W-1:0]    c_ff  [3];
   logic signed [dpwg_pkg::PROD_Z_W-1:0]  dz_ff [3];
   logic s1_valid_ff, s1_last_ff, s1_ok_ff;
   logic signed [dpwg_pkg::COL_W:0] u_s;
   logic signed [dpwg_pkg::ROW_W:0] v_s;
   logic s1_ok_in;

   assign u_s = $signed({1'b0, req_chan.pixel_column});
   assign v_s = $signed({1'b0, req_chan.pixel_row});
   assign s1_ok_in = (req_chan.inverse_depth > 0)
                     && (32'(req_chan.pixel_column) < 32'(dpwg_pkg::MAX_COLS))
                     && (32'(req_chan.pixel_row) < 32'(dpwg_pkg::MAX_ROWS));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff <= req_chan.frame_last;
         s1_ok_ff   <= s1_ok_in;
         for (int r = 0; r < 3; r++) begin
            au_ff[r] <= $signed(coef_ff[2*r][63:32]) * u_s;
            bv_ff[r] <= $signed(coef_ff[2*r][31:0]) * v_s;
            c_ff[r]  <= $signed(coef_ff[2*r+1][63:32]);
            dz_ff[r] <= $signed(coef_ff[2*r+1][31:0]) * req_chan.inverse_depth;
         end
      end
   end

   // Stage 2: row sums with 32 fraction bits
   logic signed [dpwg_pkg::SUM_W-1:0] sum_ff [3];
   logic s2_valid_ff, s2_last_ff, s2_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_last_ff <= s1_last_ff;
         s2_ok_ff   <= s1_ok_ff;
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= ((dpwg_pkg::SUM_W'(au_ff[r]) + dpwg_pkg::SUM_W'(bv_ff[r])
                          + dpwg_pkg::SUM_W'(c_ff[r])) <<< 16) + dpwg_pkg::SUM_W'(dz_ff[r]);
         end
      end
   end

   // Stage 3: sign and magnitude into the divider
   dpwg_pkg::div_stage_type div_in, div_out;
   logic [dpwg_pkg::SUM_W-1:0] mag_u, mag_v;

   always_comb begin
      mag_u = sum_ff[0][dpwg_pkg::SUM_W-1] ? (dpwg_pkg::SUM_W'(0) - sum_ff[0]) : sum_ff[0];
      mag_v = sum_ff[1][dpwg_pkg::SUM_W-1] ? (dpwg_pkg::SUM_W'(0) - sum_ff[1]) : sum_ff[1];
      div_in       = '0;
      div_in.valid = s2_valid_ff;
      div_in.last  = s2_last_ff;
      div_in.ok    = s2_ok_ff && (sum_ff[2] > 0);
      div_in.neg_u = sum_ff[0][dpwg_pkg::SUM_W-1];
      div_in.neg_v = sum_ff[1][dpwg_pkg::SUM_W-1];
      div_in.rem_u = {mag_u[dpwg_pkg::DEN_W-1:0], {dpwg_pkg::FRAC_EXTRA{1'b0}}};
      div_in.rem_v = {mag_v[dpwg_pkg::DEN_W-1:0], {dpwg_pkg::FRAC_EXTRA{1'b0}}};
      div_in.den   = sum_ff[2][dpwg_pkg::DEN_W-1:0];
   end

   dpwg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // Output register: rounding, sign, saturation, invalid masking
   logic                               rsp_valid_ff;
   logic [dpwg_pkg::COORD_W-1:0]       wu_ff, wv_ff;
   logic                               res_ok_ff, last_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ok_ff   <= div_out.ok;
         last_out_ff <= div_out.last;
         wu_ff <= div_out.ok ? dpwg_pkg::round_q16(div_out.q_u, div_out.neg_u, div_out.sat_u)
                             : '0;
         wv_ff <= div_out.ok ? dpwg_pkg::round_q16(div_out.q_v, div_out.neg_v, div_out.sat_v)
                             : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.warped_u       = $signed(wu_ff);
   assign rsp_chan.warped_v       = $signed(wv_ff);
   assign rsp_chan.valid_res      = res_ok_ff;
   assign rsp_chan.frame_last_out = last_out_ff;

   // Checks
   `DPWG_ASSERT(a_invalid_zero, (rsp_chan.valid && !rsp_chan.valid_res) |-> (rsp_chan.warped_u == 0 && rsp_chan.warped_v == 0))
   `DPWG_ASSERT(a_stall_blocks, (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
   `DPWG_ASSERT_RST(a_reset_empty, reset |=> !rsp_chan.valid)

endmodule
